// File: rtl/tfl_pkg.sv
package tfl_pkg;

  // Default fixed-point format of the cell values.
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Register widths, fixed by the register map.
  localparam int SEL_W   = 4;
  localparam int RLIM_W  = 31;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RLIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS_BND = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_BND  = 2'd3;

  // Face kinds.
  typedef enum logic [1:0] {
    OP_INTERIOR = 2'd0,
    OP_MINUS    = 2'd1,
    OP_PLUS     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // Limiter selection codes.
  typedef enum logic [SEL_W-1:0] {
    LIM_UPWIND   = 4'd0,
    LIM_SUPERBEE = 4'd1,
    LIM_CHARM    = 4'd2,
    LIM_KOREN    = 4'd3,
    LIM_MC       = 4'd4,
    LIM_OSPRE    = 4'd5,
    LIM_SMART    = 4'd6,
    LIM_VANLEER  = 4'd7,
    LIM_HCUS     = 4'd8,
    LIM_MINMOD   = 4'd9,
    LIM_HQUICK   = 4'd10
  } lim_t;

  localparam logic [SEL_W-1:0] LIM_LAST = LIM_HQUICK;

  // What an item carries on its way to the limiter.
  typedef enum logic [1:0] {
    K_FIXED  = 2'd0,
    K_CUTOFF = 2'd1,
    K_RATIO  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
    logic  big;
  } ctl_t;

  typedef struct packed {
    logic use_q;
    logic minq;
  } post_t;

  // Cutoff value of each limiter, in halves of one.
  function automatic logic [3:0] cutoff_halves(input logic [SEL_W-1:0] s);
    logic [3:0] h;
    case (s)
      LIM_SUPERBEE: h = 4'd4;
      LIM_CHARM:    h = 4'd6;
      LIM_KOREN:    h = 4'd4;
      LIM_MC:       h = 4'd4;
      LIM_OSPRE:    h = 4'd3;
      LIM_SMART:    h = 4'd8;
      LIM_VANLEER:  h = 4'd4;
      LIM_HCUS:     h = 4'd6;
      LIM_MINMOD:   h = 4'd2;
      LIM_HQUICK:   h = 4'd8;
      default:      h = 4'd0;
    endcase
    return h;
  endfunction

  // Cycles from accepted item to strobed result.
  function automatic int pipe_latency(input int f);
    return 3 + RLIM_W + 3 + (f + 2) + 1;
  endfunction

endpackage

// File: rtl/tfl_div.sv
// Restoring divider, one quotient bit per register stage.
// The caller guarantees that rem0 is below den.
module tfl_div import tfl_pkg::*; #(
  parameter int DW = 33,
  parameter int QW = 31,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] low,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] pay,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] pay_out
);

  logic [QW-1:0] vld;
  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] q_r   [QW];
  logic [PW-1:0] pay_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [PW-1:0] pay_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = rem0;
      assign den_in = den;
      assign low_in = low;
      assign q_in   = '0;
      assign pay_in = pay;
    end else begin : g_next
      assign v_in   = vld[s-1];
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign low_in = low_r[s-1];
      assign q_in   = q_r[s-1];
      assign pay_in = pay_r[s-1];
    end

    // Bring down the next bit and try a subtraction.
    assign trial = {rem_in, low_in[QW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= fits ? diff[DW-1:0] : trial[DW-1:0];
      den_r[s] <= den_in;
      low_r[s] <= {low_in[QW-2:0], 1'b0};
      q_r[s]   <= {q_in[QW-2:0], fits};
      pay_r[s] <= pay_in;
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = q_r[QW-1];
  assign pay_out   = pay_r[QW-1];

endmodule

// File: rtl/tfl_front.sv
// Face decode: picks the upwind differences, takes magnitudes and sets up
// the ratio division. Three register stages.
module tfl_front import tfl_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [1:0]                    op,
  input  logic signed [VALUE_WIDTH-1:0] velocity,
  input  logic signed [VALUE_WIDTH-1:0] value_0,
  input  logic signed [VALUE_WIDTH-1:0] value_1,
  input  logic signed [VALUE_WIDTH-1:0] value_2,
  input  logic signed [VALUE_WIDTH-1:0] value_3,
  input  logic [SEL_W-1:0]              sel,
  input  logic                          minus_bnd,
  input  logic                          plus_bnd,
  output logic                          out_valid,
  output ctl_t                          ctl,
  output logic [FRAC_BITS+2:0]          fixv,
  output logic [VALUE_WIDTH:0]          rem0,
  output logic [RLIM_W-1:0]             low,
  output logic [VALUE_WIDTH:0]          den
);

  localparam int VW = VALUE_WIDTH;
  localparam int DW = VALUE_WIDTH + 1;
  localparam int PW = FRAC_BITS + 3;
  localparam int SH = RLIM_W - FRAC_BITS;
  localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

  logic [DW-1:0] x0, x1, x2, x3;
  logic [DW-1:0] d10, d21, d32;
  logic          vel_pos, vel_neg, dir_pos, dir_neg, bnd;

  kind_t         kind_next;
  logic [PW-1:0] fix_next;
  logic [DW-1:0] num_next, den_next;

  logic          v1;
  kind_t         kind1;
  logic [PW-1:0] fix1;
  logic [DW-1:0] num1, den1;

  logic          v2;
  kind_t         kind2;
  logic [PW-1:0] fix2;
  logic          neg2;
  logic [DW-1:0] nmag2, dmag2;
  logic [DW-1:0] rem_sh;

  // Differences of neighbouring cells, one bit wider than the values.
  assign x0  = {value_0[VW-1], value_0};
  assign x1  = {value_1[VW-1], value_1};
  assign x2  = {value_2[VW-1], value_2};
  assign x3  = {value_3[VW-1], value_3};
  assign d10 = x1 - x0;
  assign d21 = x2 - x1;
  assign d32 = x3 - x2;

  assign vel_neg = velocity[VW-1];
  assign vel_pos = !velocity[VW-1] && (velocity != '0);
  assign dir_pos = (op == OP_MINUS) ? vel_neg : vel_pos;
  assign dir_neg = (op == OP_MINUS) ? vel_pos : vel_neg;
  assign bnd     = (op == OP_MINUS) ? minus_bnd : plus_bnd;

  // Choose the upwind ratio, or settle the weight outright.
  always_comb begin
    kind_next = K_FIXED;
    fix_next  = '0;
    num_next  = d21;
    den_next  = d10;
    if (sel <= LIM_LAST) begin
      case (op)
        OP_INTERIOR: begin
          if (sel != LIM_UPWIND) begin
            if (vel_pos) begin
              kind_next = K_RATIO;
              num_next  = d10;
              den_next  = d21;
            end else if (vel_neg) begin
              kind_next = K_RATIO;
              num_next  = d32;
              den_next  = d21;
            end else begin
              fix_next = ONE;
            end
          end
        end
        OP_MINUS, OP_PLUS: begin
          if (dir_pos) begin
            kind_next = K_RATIO;
          end else if (dir_neg) begin
            fix_next = bnd ? ONE : '0;
          end else begin
            fix_next = ONE;
          end
        end
        default: begin
          fix_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  // Stage one: selected differences.
  always_ff @(posedge clk) begin
    kind1 <= kind_next;
    fix1  <= fix_next;
    num1  <= num_next;
    den1  <= den_next;
  end

  // Stage two: magnitudes, sign of the ratio and a zero denominator.
  always_ff @(posedge clk) begin
    kind2 <= (kind1 == K_RATIO && den1 == '0) ? K_CUTOFF : kind1;
    fix2  <= fix1;
    neg2  <= num1[DW-1] ^ den1[DW-1];
    nmag2 <= num1[DW-1] ? (~num1 + DW'(1)) : num1;
    dmag2 <= den1[DW-1] ? (~den1 + DW'(1)) : den1;
  end

  // Stage three: first partial remainder; a quotient of 2^31 or more is flagged.
  assign rem_sh = nmag2 >> SH;

  always_ff @(posedge clk) begin
    ctl.kind <= kind2;
    ctl.neg  <= neg2;
    ctl.big  <= rem_sh >= dmag2;
    fixv     <= fix2;
    rem0     <= rem_sh;
    low      <= {nmag2[SH-1:0], {FRAC_BITS{1'b0}}};
    den      <= dmag2;
  end

endmodule

// File: rtl/tfl_shape.sv
// Limiter shaping: resolves the ratio against r_limit, evaluates the simple
// limiters and forms the quotient operands of the rational ones.
module tfl_shape import tfl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  ctl_t                       ctl,
  input  logic [FRAC_BITS+2:0]       fixv,
  input  logic [RLIM_W-1:0]          q,
  input  logic [SEL_W-1:0]           sel,
  input  logic [RLIM_W-1:0]          rlim,
  output logic                       out_valid,
  output logic [2*RLIM_W+2:0]        n2,
  output logic [2*RLIM_W+2:0]        d2,
  output post_t                      post,
  output logic [FRAC_BITS+2:0]       val,
  output logic [FRAC_BITS+2:0]       alt
);

  localparam int PW  = FRAC_BITS + 3;
  localparam int EW  = RLIM_W + 3;
  localparam int DW2 = 2 * RLIM_W + 3;

  logic          neg_eff;
  kind_t         cls_next;
  logic [PW-1:0] v1_next;

  logic              va, vb;
  kind_t             cls1;
  logic [PW-1:0]     v1;
  logic [RLIM_W-1:0] ur1;

  logic [EW-1:0] r, r2x, r3x, one_e, two_e, four_e;
  logic [EW-1:0] sb_a, sb_b, mc_h, mc_m, sm_t, sm_m, kor_alt;
  logic [EW-1:0] sv_next, alt_next;
  post_t         post_next;

  logic [2*RLIM_W-1:0] sq2;
  logic [RLIM_W-1:0]   ur2;
  post_t               post2;
  logic [PW-1:0]       v2, alt2;

  logic [DW2-1:0] urw, sqw, one_w, osp_n;
  logic [DW2-1:0] n_next, d_next;

  // Stage one: a ratio at or above r_limit or with no denominator takes the cutoff.
  assign neg_eff = ctl.neg && (ctl.big || q != '0);

  always_comb begin
    cls_next = K_FIXED;
    v1_next  = fixv;
    case (ctl.kind)
      K_CUTOFF: cls_next = K_CUTOFF;
      K_RATIO: begin
        if (!neg_eff && (ctl.big || q >= rlim)) begin
          cls_next = K_CUTOFF;
        end else if (neg_eff || q == '0) begin
          v1_next = '0;
        end else begin
          cls_next = K_RATIO;
        end
      end
      default: cls_next = K_FIXED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    cls1 <= cls_next;
    v1   <= v1_next;
    ur1  <= q;
  end

  // Stage two: the piecewise-linear limiters.
  assign r      = EW'(ur1);
  assign r2x    = r << 1;
  assign r3x    = r + r2x;
  assign one_e  = EW'(1) << FRAC_BITS;
  assign two_e  = EW'(2) << FRAC_BITS;
  assign four_e = EW'(4) << FRAC_BITS;
  assign sb_a   = (r2x < one_e) ? r2x : one_e;
  assign sb_b   = (r < two_e) ? r : two_e;
  assign mc_h   = (r + one_e) >> 1;
  assign mc_m   = (r2x < mc_h) ? r2x : mc_h;
  assign sm_t   = (r3x + one_e) >> 2;
  assign sm_m   = (r2x < sm_t) ? r2x : sm_t;
  assign kor_alt = (r2x < two_e) ? r2x : two_e;

  always_comb begin
    sv_next   = '0;
    alt_next  = '0;
    post_next = '0;
    case (cls1)
      K_CUTOFF: sv_next = EW'(cutoff_halves(sel)) << (FRAC_BITS - 1);
      K_RATIO: begin
        case (sel)
          LIM_SUPERBEE: sv_next = (sb_a > sb_b) ? sb_a : sb_b;
          LIM_MC:       sv_next = (mc_m < two_e) ? mc_m : two_e;
          LIM_SMART:    sv_next = (sm_m < four_e) ? sm_m : four_e;
          LIM_MINMOD:   sv_next = (r < one_e) ? r : one_e;
          LIM_KOREN: begin
            if (r >= four_e) begin
              sv_next = two_e;
            end else begin
              post_next.use_q = 1'b1;
              post_next.minq  = 1'b1;
              alt_next        = kor_alt;
            end
          end
          LIM_CHARM, LIM_OSPRE, LIM_VANLEER, LIM_HCUS, LIM_HQUICK: begin
            post_next.use_q = 1'b1;
          end
          default: sv_next = '0;
        endcase
      end
      default: sv_next = EW'(v1);
    endcase
  end

  always_ff @(posedge clk) begin
    sq2   <= ur1 * ur1;
    ur2   <= ur1;
    post2 <= post_next;
    v2    <= sv_next[PW-1:0];
    alt2  <= alt_next[PW-1:0];
  end

  // Stage three: numerator and denominator of the rational limiters.
  assign urw   = DW2'(ur2);
  assign sqw   = DW2'(sq2);
  assign one_w = DW2'(1) << FRAC_BITS;
  assign osp_n = sqw + (urw << FRAC_BITS);

  always_comb begin
    n_next = '0;
    d_next = DW2'(1);
    case (sel)
      LIM_CHARM: begin
        n_next = (sqw << 1) + sqw + (urw << FRAC_BITS);
        d_next = sqw + (urw << (FRAC_BITS + 1)) + (DW2'(1) << (2 * FRAC_BITS));
      end
      LIM_OSPRE: begin
        n_next = (osp_n << 1) + osp_n;
        d_next = (osp_n << 1) + (DW2'(1) << (2 * FRAC_BITS + 1));
      end
      LIM_VANLEER: begin
        n_next = urw << 1;
        d_next = urw + one_w;
      end
      LIM_HCUS: begin
        n_next = (urw << 1) + urw;
        d_next = urw + (one_w << 1);
      end
      LIM_HQUICK: begin
        n_next = urw << 2;
        d_next = urw + (one_w << 1) + one_w;
      end
      LIM_KOREN: begin
        n_next = urw + (one_w << 1);
        d_next = (one_w << 1) + one_w;
      end
      default: begin
        n_next = '0;
        d_next = DW2'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n2   <= n_next;
    d2   <= d_next;
    post <= post2;
    val  <= v2;
    alt  <= alt2;
  end

endmodule

// File: rtl/tvd_flux_limiter_face.sv
// Channel   Ports                                          Direction
// command   start, busy, op, velocity, value_0..value_3    in (busy out)
// result    done, psi                                      out
// config    cfg_we, cfg_index, cfg_data                    in
//
// One item is accepted in every cycle while busy is low, and its psi appears
// together with done. The latency is set by the two bit-serial dividers: 31
// stages for the ratio r and FRAC_BITS + 2 stages for the rational limiters,
// plus seven stages of decode, shaping and the result register.
// Reset clears every valid bit and the configuration registers; busy is high during reset.
// The receiver cannot stall, so the pipeline never holds.
module tvd_flux_limiter_face import tfl_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic signed [VALUE_WIDTH-1:0] velocity,
  input  logic signed [VALUE_WIDTH-1:0] value_0,
  input  logic signed [VALUE_WIDTH-1:0] value_1,
  input  logic signed [VALUE_WIDTH-1:0] value_2,
  input  logic signed [VALUE_WIDTH-1:0] value_3,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic                          done,
  output logic [FRAC_BITS+2:0]          psi
);

  localparam int PW  = FRAC_BITS + 3;
  localparam int DW1 = VALUE_WIDTH + 1;
  localparam int DW2 = 2 * RLIM_W + 3;
  localparam int QW2 = FRAC_BITS + 2;
  localparam int P1W = $bits(ctl_t) + PW;
  localparam int P2W = $bits(post_t) + 2 * PW;

  logic [SEL_W-1:0]  sel;
  logic [RLIM_W-1:0] rlim;
  logic              minus_bnd, plus_bnd;

  logic              f_valid;
  ctl_t              f_ctl;
  logic [PW-1:0]     f_fix;
  logic [DW1-1:0]    f_rem0, f_den;
  logic [RLIM_W-1:0] f_low;

  logic              r_valid;
  logic [RLIM_W-1:0] r_q;
  logic [P1W-1:0]    r_pay;
  ctl_t              r_ctl;
  logic [PW-1:0]     r_fix;

  logic           s_valid;
  logic [DW2-1:0] s_n, s_d;
  post_t          s_post;
  logic [PW-1:0]  s_val, s_alt;

  logic           l_valid;
  logic [QW2-1:0] l_q;
  logic [P2W-1:0] l_pay;
  post_t          l_post;
  logic [PW-1:0]  l_val, l_alt, l_qx;
  logic [PW-1:0]  psi_next;

  assign busy = rst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel       <= LIM_UPWIND;
      rlim      <= '1;
      minus_bnd <= 1'b0;
      plus_bnd  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SELECT:    sel       <= cfg_data[SEL_W-1:0];
        CFG_RLIMIT:    rlim      <= cfg_data[RLIM_W-1:0];
        CFG_MINUS_BND: minus_bnd <= cfg_data[0];
        CFG_PLUS_BND:  plus_bnd  <= cfg_data[0];
        default:       sel       <= sel;
      endcase
    end
  end

  tfl_front #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .op        (op),
    .velocity  (velocity),
    .value_0   (value_0),
    .value_1   (value_1),
    .value_2   (value_2),
    .value_3   (value_3),
    .sel       (sel),
    .minus_bnd (minus_bnd),
    .plus_bnd  (plus_bnd),
    .out_valid (f_valid),
    .ctl       (f_ctl),
    .fixv      (f_fix),
    .rem0      (f_rem0),
    .low       (f_low),
    .den       (f_den)
  );

  // Ratio magnitude |num| * 2^FRAC_BITS / |den|, below 2^31 unless flagged big.
  tfl_div #(.DW(DW1), .QW(RLIM_W), .PW(P1W)) u_rdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .rem0      (f_rem0),
    .low       (f_low),
    .den       (f_den),
    .pay       ({f_ctl, f_fix}),
    .out_valid (r_valid),
    .quo       (r_q),
    .pay_out   (r_pay)
  );

  assign {r_ctl, r_fix} = r_pay;

  tfl_shape #(.FRAC_BITS(FRAC_BITS)) u_shape (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .ctl       (r_ctl),
    .fixv      (r_fix),
    .q         (r_q),
    .sel       (sel),
    .rlim      (rlim),
    .out_valid (s_valid),
    .n2        (s_n),
    .d2        (s_d),
    .post      (s_post),
    .val       (s_val),
    .alt       (s_alt)
  );

  // Limiter quotient; every rational limiter stays below 4.0.
  tfl_div #(.DW(DW2), .QW(QW2), .PW(P2W)) u_ldiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .rem0      (s_n >> 2),
    .low       ({s_n[1:0], {FRAC_BITS{1'b0}}}),
    .den       (s_d),
    .pay       ({s_post, s_val, s_alt}),
    .out_valid (l_valid),
    .quo       (l_q),
    .pay_out   (l_pay)
  );

  assign {l_post, l_val, l_alt} = l_pay;
  assign l_qx = PW'(l_q);

  // Result register.
  always_comb begin
    psi_next = l_val;
    if (l_post.use_q) begin
      psi_next = (l_post.minq && l_alt < l_qx) ? l_alt : l_qx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    psi <= psi_next;
  end

endmodule

// File: rtl/tfl_checker.sv
module tfl_checker import tfl_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           op,
  input logic                 done,
  input logic [FRAC_BITS+2:0] psi
);

  localparam int LAT = pipe_latency(FRAC_BITS);
  localparam logic [FRAC_BITS+2:0] FOUR = (FRAC_BITS + 3)'(4) << FRAC_BITS;

  // The weight never exceeds four.
  a_psi_range: assert property (@(posedge clk) disable iff (rst)
    done |-> psi <= FOUR)
    else $error("psi above 4.0");

  // Every result belongs to an item accepted a fixed latency earlier.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching item");

  // Every accepted item yields its result after the fixed latency.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("item lost in the pipeline");

  // An unused face code always gives a zero weight.
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_NONE) |-> ##LAT (psi == '0))
    else $error("unused face code gave a nonzero weight");

endmodule

bind tvd_flux_limiter_face tfl_checker #(
  .FRAC_BITS   (FRAC_BITS),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_tfl_checker (.*);
